@@ rtl/ids_pkg.sv @@
// Shared types, constants and codes for the indexed deque store.
package ids_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_INSERT     = 4'd4,
        OP_REMOVE     = 4'd5,
        OP_READ       = 4'd6,
        OP_FRONT      = 4'd7,
        OP_BACK       = 4'd8,
        OP_REVERSE    = 4'd9,
        OP_CLEAR      = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD    = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_REVERSE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        logic [3:0]        opcode;
        logic signed [31:0] item_value;
        logic [4:0]        position;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]        status;
        logic [4:0]        element_count;
        logic              is_empty;
    } out_beat_t;

    // Command broadcast along the cell chain.
    typedef struct packed {
        cell_cmd_t        cmd;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

    // Full decode of one operation against the current count.
    typedef struct packed {
        cell_ctrl_t       chain;
        status_t          status;
        logic [CNT_W-1:0] count_next;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } op_decode_t;

endpackage

@@ rtl/ids_decode.sv @@
// Operation decoder: status, new count, read index and chain command.
module ids_decode (
    input  logic [3:0]               opcode,
    input  logic [4:0]               position,
    input  logic [ids_pkg::CNT_W-1:0] count,
    output ids_pkg::op_decode_t      dec
);
    import ids_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic             empty;
    logic             full;
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] last;

    assign empty   = (count == '0);
    assign full    = (count >= CNT_FULL);
    assign pos_ext = CNT_W'(position);
    assign last    = count - CNT_ONE;

    always_comb begin
        dec.chain.cmd   = CMD_HOLD;
        dec.chain.pos   = '0;
        dec.chain.count = count;
        dec.status      = ST_OK;
        dec.count_next  = count;
        dec.rd_en       = 1'b0;
        dec.rd_idx      = '0;
        unique case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (full) begin
                    dec.status = ST_FULL;
                end else begin
                    dec.chain.cmd  = CMD_INSERT;
                    dec.chain.pos  = (opcode == OP_PUSH_FRONT) ? '0 : count;
                    dec.count_next = count + CNT_ONE;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                    dec.status = ST_EMPTY;
                end else begin
                    dec.chain.cmd  = CMD_REMOVE;
                    dec.chain.pos  = (opcode == OP_POP_FRONT) ? '0 : last;
                    dec.rd_en      = 1'b1;
                    dec.rd_idx     = (opcode == OP_POP_FRONT) ? '0 : last[IDX_W-1:0];
                    dec.count_next = last;
                end
            end
            OP_INSERT: begin
                if (pos_ext > count) begin
                    dec.status = ST_RANGE;
                end else if (full) begin
                    dec.status = ST_FULL;
                end else begin
                    dec.chain.cmd  = CMD_INSERT;
                    dec.chain.pos  = pos_ext;
                    dec.count_next = count + CNT_ONE;
                end
            end
            OP_REMOVE: begin
                if (pos_ext >= count) begin
                    dec.status = ST_RANGE;
                end else begin
                    dec.chain.cmd  = CMD_REMOVE;
                    dec.chain.pos  = pos_ext;
                    dec.count_next = last;
                end
            end
            OP_READ: begin
                if (pos_ext >= count) begin
                    dec.status = ST_RANGE;
                end else begin
                    dec.rd_en  = 1'b1;
                    dec.rd_idx = pos_ext[IDX_W-1:0];
                end
            end
            OP_FRONT, OP_BACK: begin
                if (empty) begin
                    dec.status = ST_EMPTY;
                end else begin
                    dec.rd_en  = 1'b1;
                    dec.rd_idx = (opcode == OP_FRONT) ? '0 : last[IDX_W-1:0];
                end
            end
            OP_REVERSE: begin
                if (empty) begin
                    dec.status = ST_EMPTY;
                end else begin
                    dec.chain.cmd = CMD_REVERSE;
                end
            end
            OP_CLEAR: begin
                dec.count_next = '0;
            end
            default: begin
                dec.status = ST_RANGE;
            end
        endcase
    end

endmodule

@@ rtl/ids_cell.sv @@
// One storage cell of the chain: holds a single entry and shifts with its neighbours.
module ids_cell (
    input  logic                           aclk,
    input  ids_pkg::cell_ctrl_t            ctrl,
    input  logic [ids_pkg::IDX_W-1:0]      cell_idx,
    input  logic [ids_pkg::DATA_WIDTH-1:0] left_val,
    input  logic [ids_pkg::DATA_WIDTH-1:0] right_val,
    input  logic [ids_pkg::DATA_WIDTH-1:0] mirror_val,
    input  logic [ids_pkg::DATA_WIDTH-1:0] new_val,
    output logic [ids_pkg::DATA_WIDTH-1:0] value
);
    import ids_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic [CNT_W-1:0]      idx_ext;

    assign idx_ext = CNT_W'(cell_idx);

    always_comb begin
        value_next = value_reg;
        case (ctrl.cmd)
            CMD_INSERT: begin
                if (idx_ext == ctrl.pos) begin
                    value_next = new_val;
                end else if (idx_ext > ctrl.pos) begin
                    value_next = left_val;
                end
            end
            CMD_REMOVE: begin
                if (idx_ext >= ctrl.pos) begin
                    value_next = right_val;
                end
            end
            CMD_REVERSE: begin
                if (idx_ext < ctrl.count) begin
                    value_next = mirror_val;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ rtl/indexed_deque_store_top.sv @@
// Top level of the indexed deque store: decoder, cell chain and result register.
// Results: the result beat of an accepted input beat is registered and shown on m_ in the cycle after it.
// Throughput: one beat per cycle while m_ready is high; every operation, including
// insert, remove and reverse, completes in a single shift of the cell chain.
// Reset: aresetn (synchronous, active low) empties the store and clears m_valid;
// entry contents are not cleared and are never read before being written.
module indexed_deque_store_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ids_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ids_pkg::out_beat_t m_data
);
    import ids_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    out_beat_t             m_data_reg;
    out_beat_t             m_data_next;
    logic                  accept;
    op_decode_t            dec;
    cell_ctrl_t            chain_ctrl;
    logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_val;

    ids_decode u_decode (
        .opcode   (s_data.opcode),
        .position (s_data.position),
        .count    (count_reg),
        .dec      (dec)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        chain_ctrl = dec.chain;
        if (!accept) begin
            chain_ctrl.cmd = CMD_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_val;
            logic [DATA_WIDTH-1:0] right_val;
            logic [CNT_W-1:0]      mirror_full;
            logic [IDX_W-1:0]      mirror_idx;

            if (gi == 0) begin : g_first
                assign left_val = '0;
            end else begin : g_mid_l
                assign left_val = cell_val[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_val = '0;
            end else begin : g_mid_r
                assign right_val = cell_val[gi+1];
            end

            // Partner of this cell when the held entries are reversed.
            assign mirror_full = count_reg - CNT_W'(1) - CNT_W'(gi);
            assign mirror_idx  = mirror_full[IDX_W-1:0];

            ids_cell u_cell (
                .aclk       (aclk),
                .ctrl       (chain_ctrl),
                .cell_idx   (IDX_W'(gi)),
                .left_val   (left_val),
                .right_val  (right_val),
                .mirror_val (cell_val[mirror_idx]),
                .new_val    (s_data.item_value[DATA_WIDTH-1:0]),
                .value      (cell_val[gi])
            );
        end
    endgenerate

    assign rd_val = cell_val[dec.rd_idx];

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            count_next   = dec.count_next;
            m_valid_next = 1'b1;
            if (dec.status != ST_OK) begin
                m_data_next.result_value = -32'sd1;
            end else if (dec.rd_en) begin
                m_data_next.result_value = 32'(signed'(rd_val));
            end else begin
                m_data_next.result_value = '0;
            end
            m_data_next.status        = dec.status;
            m_data_next.element_count = 5'(dec.count_next);
            m_data_next.is_empty      = (dec.count_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
